// ----- rtl/lnds_pkg.sv -----
package lnds_pkg;

   // Default capacity of the tail store, in entries.
   localparam int unsigned MAX_LEN_DEFAULT = 1024;

   // Fixed widths of the request and response fields.
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned LEN_OUT_W = 11;

   // Result handed from the search engine to the output stage.
   typedef struct packed {
      logic [LEN_OUT_W-1:0] length;
      logic                 overflow;
   } lnds_result_type;

endpackage

// ----- rtl/lnds_ram.sv -----
module lnds_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lnds_engine.sv -----
module lnds_engine #(
   parameter int unsigned MAX_LEN = lnds_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [lnds_pkg::VALUE_W-1:0] req_value,
   input  logic                                req_first,
   output logic                                res_valid,
   input  logic                                res_ready,
   output lnds_pkg::lnds_result_type           res
);

   localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int unsigned LW = $clog2(MAX_LEN + 1);
   localparam int unsigned OW = lnds_pkg::LEN_OUT_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_LOOKUP = 4'b0010,
      ST_PLACE  = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic signed [lnds_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [LW-1:0]                      lo_ff, lo_in;
   logic [LW-1:0]                      hi_ff, hi_in;
   logic [LW-1:0]                      mid_ff, mid_in;
   logic [LW-1:0]                      run_len_ff, run_len_in;
   logic                               ovf_ff, ovf_in;

   logic                               rd_en;
   logic [AW-1:0]                      rd_addr;
   logic signed [lnds_pkg::VALUE_W-1:0] rd_data;
   logic                               wr_en;

   logic [LW-1:0]                      len_start;
   logic                               greater;
   logic [LW-1:0]                      lo_next, hi_next, mid_next;
   logic [LW+OW-1:0]                   len_wide;

   lnds_ram #(
      .WIDTH (lnds_pkg::VALUE_W),
      .DEPTH (MAX_LEN)
   ) u_tails (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (lo_ff[AW-1:0]),
      .wr_data (value_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign len_start = req_first ? '0 : run_len_ff;
   assign greater   = rd_data > value_ff;
   assign lo_next   = greater ? lo_ff : LW'(mid_ff + 1'b1);
   assign hi_next   = greater ? mid_ff : hi_ff;
   assign mid_next  = LW'(lo_next + ((hi_next - lo_next) >> 1));

   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      run_len_in = run_len_ff;
      ovf_in     = ovf_ff;
      rd_en      = 1'b0;
      rd_addr    = mid_next[AW-1:0];
      wr_en      = 1'b0;
      req_ready  = 1'b0;
      res_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               value_in   = req_value;
               run_len_in = len_start;
               ovf_in     = req_first ? 1'b0 : ovf_ff;
               lo_in      = '0;
               hi_in      = len_start;
               mid_in     = len_start >> 1;
               rd_addr    = mid_in[AW-1:0];
               if (len_start != '0) begin
                  rd_en    = 1'b1;
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_PLACE;
               end
            end
         end
         ST_LOOKUP: begin
            lo_in  = lo_next;
            hi_in  = hi_next;
            mid_in = mid_next;
            if (lo_next < hi_next) begin
               rd_en = 1'b1;
            end else begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            // lo is the insertion point; it equals run_len when nothing is greater.
            if (lo_ff < run_len_ff) begin
               wr_en = 1'b1;
            end else if (run_len_ff != LW'(MAX_LEN)) begin
               wr_en      = 1'b1;
               run_len_in = LW'(run_len_ff + 1'b1);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign len_wide     = {{OW{1'b0}}, run_len_ff};
   assign res.length   = len_wide[OW-1:0];
   assign res.overflow = ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         run_len_ff <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         run_len_ff <= run_len_in;
         ovf_ff     <= ovf_in;
      end
      value_ff <= value_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
   end

endmodule

// ----- rtl/longest_nondecreasing_subsequence_core.sv -----
// Longest non-decreasing subsequence tracker, patience-sorting style.
// The req_ channel carries one signed 32-bit value per request, with
// req_first set to start a new sequence. The rsp_ channel returns one
// response per request: the running subsequence length and a sticky flag
// that is set when an append was dropped because the tail store was full.
// Smallest tails per length live in a single-port-read, single-port-write
// memory of MAX_LEN entries with a registered read. Each request runs a
// binary search over the stored tails, one memory read per cycle, and then
// writes the value at the insertion point, unless that would append to a
// full store. One request is processed at a time: the engine returns to
// idle after handing its result on before it takes the next request.
// A finished response sits in an output register, so the engine already
// takes the next request while rsp_ready is low; a second result waits in
// the engine until the register frees up. Reset is synchronous and clears
// the length and overflow flag; the memory itself is not cleared, because
// only entries below the current length are read.
module longest_nondecreasing_subsequence_core #(
   parameter int unsigned MAX_LEN = lnds_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [lnds_pkg::VALUE_W-1:0]   req_value,
   input  logic                                  req_first,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic        [lnds_pkg::LEN_OUT_W-1:0] rsp_length,
   output logic                                  rsp_overflow
);

   lnds_pkg::lnds_result_type res;
   logic                      res_valid;
   logic                      res_ready;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [lnds_pkg::LEN_OUT_W-1:0]     rsp_length_ff, rsp_length_in;
   logic                               rsp_overflow_ff, rsp_overflow_in;

   // The search engine owns the tail memory, the length and the flag.
   lnds_engine #(
      .MAX_LEN (MAX_LEN)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .req_first (req_first),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The output register can take a new result when it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_length_in   = rsp_length_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in    = 1'b1;
         rsp_length_in   = res.length;
         rsp_overflow_in = res.overflow;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_length_ff   <= rsp_length_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ----- tb/longest_nondecreasing_subsequence_core_tb.sv -----
// Self-checking testbench for the patience-sorting subsequence tracker.
//
// A small tracker class keeps its own copy of the tail store, the running
// length and the sticky overflow flag. Every accepted request is run through
// it at once, and the length and flag it predicts are queued. Every accepted
// response is compared with the oldest queued prediction.
//
// Stimulus starts with a short directed sweep: field extremes, equal values,
// decreasing runs and back-to-back first flags. Random runs follow. Most of
// them start with a first flag and carry scattered, clustered or rising
// values; a few continue the previous sequence or drop a stray first flag in
// the middle. One long rising run fills the whole store, so that appends get
// dropped and the overflow flag sets, and the run after it clears the flag.
module longest_nondecreasing_subsequence_core_tb;

   localparam int unsigned STORE_DEPTH = lnds_pkg::MAX_LEN_DEFAULT;

   // Cycles in which neither channel moves a request or a response before
   // the run is declared hung. The longest legitimate quiet stretch is the
   // deliberate receiver hold-off plus one search.
   localparam int unsigned STALL_LIMIT = 5000;

   // Length of the deliberate receiver hold-off, in clock cycles.
   localparam int unsigned HOLD_CYCLES = 300;

   // Cycles to wait after the last response, to catch a stray one.
   localparam int unsigned DRAIN_CYCLES = 40;

   // Value patterns for a random run.
   typedef enum int unsigned {
      RUN_SCATTERED,
      RUN_CLUSTERED,
      RUN_RISING
   } run_kind_type;

   // Predicts the length and overflow flag that each request yields.
   class tail_tracker_type;
      logic signed [lnds_pkg::VALUE_W-1:0] tails [STORE_DEPTH];
      int unsigned                         count;
      bit                                  dropped;
      lnds_pkg::lnds_result_type           awaited_results [$];
      int unsigned                         errors;
      int unsigned                         checked;

      function new();
         count   = 0;
         dropped = 0;
         errors  = 0;
         checked = 0;
      endfunction

      function void note_request(logic signed [lnds_pkg::VALUE_W-1:0] value, logic first);
         int unsigned               lo;
         int unsigned               hi;
         int unsigned               mid;
         lnds_pkg::lnds_result_type res;
         if (first) begin
            count   = 0;
            dropped = 0;
         end
         // Find the first tail strictly greater than the value, so equal
         // values land after their peers and extend the subsequence.
         lo = 0;
         hi = count;
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (tails[mid] > value) hi = mid;
            else lo = mid + 1;
         end
         if (lo < count) begin
            tails[lo] = value;
         end else if (count < STORE_DEPTH) begin
            tails[count] = value;
            count++;
         end else begin
            dropped = 1'b1;
         end
         res.length   = count[lnds_pkg::LEN_OUT_W-1:0];
         res.overflow = dropped;
         awaited_results.insert(awaited_results.size(), res);
      endfunction

      function void check_response(logic [lnds_pkg::LEN_OUT_W-1:0] length, logic overflow);
         lnds_pkg::lnds_result_type exp;
         if (awaited_results.size() == 0) begin
            $display("%0t: response with nothing expected: length=%0d overflow=%0b",
                     $time, length, overflow);
            errors++;
            return;
         end
         exp = awaited_results.pop_front();
         if (exp.length !== length || exp.overflow !== overflow) begin
            $display("%0t: response %0d: expected length=%0d overflow=%0b,",
                     $time, checked, exp.length, exp.overflow);
            $display("   got length=%0d overflow=%0b", length, overflow);
            errors++;
         end
         checked++;
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic signed [lnds_pkg::VALUE_W-1:0]   req_value;
   logic                                  req_first;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic        [lnds_pkg::LEN_OUT_W-1:0] rsp_length;
   logic                                  rsp_overflow;

   tail_tracker_type tracker = new();

   // Idle rates in percent, changed by the main sequence at phase starts.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // Set once by the main sequence; the response side then holds off.
   bit hold_pending = 1'b0;

   // Running level for rising runs, kept wide so it can be clamped.
   longint rise_level = 0;

   longest_nondecreasing_subsequence_core #(
      .MAX_LEN(STORE_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .req_first   (req_first),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_length  (rsp_length),
      .rsp_overflow(rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Responses are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         tracker.check_response(rsp_length, rsp_overflow);
      end
   end

   // Response side: random back-pressure, plus one long hold-off counted
   // here so that the block fills and has to stall its request port.
   initial begin : response_side
      int unsigned hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_pending = 1'b0;
         end
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog: counts cycles in which no request and no response is taken.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("longest_nondecreasing_subsequence_core: mismatch");
      $finish;
   end

   // Offers one request. Called at a falling edge and returns at the falling
   // edge after acceptance with req_valid still high, so a following request
   // can go out without valid dropping in between. The caller lowers valid
   // after the last one.
   task automatic offer_request(input logic signed [lnds_pkg::VALUE_W-1:0] value,
                                input logic first);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      req_first <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_request(value, first);
      @(negedge clock);
   endtask

   // Next value of a rising run: mostly a small step up, with equal steps
   // now and then, and one in ten a scattered value that lands inside.
   function automatic logic signed [lnds_pkg::VALUE_W-1:0] rising_value();
      if ($urandom_range(9) == 0) return $urandom;
      rise_level = rise_level + longint'($urandom_range(1 << 20));
      if (rise_level > 64'sd2147483647) rise_level = 64'sd2147483647;
      return rise_level[lnds_pkg::VALUE_W-1:0];
   endfunction

   function automatic logic signed [lnds_pkg::VALUE_W-1:0] run_value(input run_kind_type kind);
      case (kind)
         RUN_SCATTERED: return $urandom;
         RUN_CLUSTERED: return int'($urandom_range(15)) - 8;
         default:       return rising_value();
      endcase
   endfunction

   // One run of requests. A fresh run opens with a first flag; a few stray
   // first flags fall in the middle, which breaks the sequence.
   task automatic send_run(input int unsigned run_len, input run_kind_type kind,
                           input bit fresh);
      int unsigned i;
      logic        first;
      rise_level = -64'sd2147483648 + longint'($urandom_range(1 << 30));
      for (i = 0; i < run_len; i++) begin
         first = (i == 0 && fresh) || ($urandom_range(99) < 3);
         offer_request(run_value(kind), first);
      end
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned sent;
      int unsigned run_len;
      sent = 0;
      while (sent < quota) begin
         run_len = $urandom_range(1, 40);
         send_run(run_len, run_kind_type'($urandom_range(2)), $urandom_range(9) != 0);
         sent += run_len;
      end
   endtask

   // One long rising run that fills the store, then keeps appending so that
   // the extra values are dropped and the overflow flag sets.
   task automatic fill_store();
      int unsigned i;
      rise_level = -64'sd2147483648 + longint'($urandom_range(1 << 20));
      offer_request(rising_value(), 1'b1);
      i = 0;
      while (tracker.count < STORE_DEPTH && i < 3000) begin
         offer_request(rising_value(), 1'b0);
         i++;
      end
      for (i = 0; i < 40; i++) offer_request(rising_value(), 1'b0);
      // A fresh run right after the overflow must clear the flag.
      send_run(20, RUN_SCATTERED, 1'b1);
   endtask

   initial begin : main_sequence
      int unsigned k;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      req_first = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed sweep. The first request carries no first flag: after reset
      // the store is already empty.
      offer_request(32'sd0, 1'b0);
      offer_request(32'sd0, 1'b0);                 // equal value extends
      offer_request(-32'sd2147483648, 1'b0);       // most negative replaces the head
      offer_request(32'sd2147483647, 1'b0);        // most positive appends
      offer_request(32'sd2147483647, 1'b0);        // equal to the top appends again
      offer_request(-32'sd1, 1'b0);
      offer_request(32'sd0, 1'b0);
      offer_request(32'sd2147483647, 1'b1);        // first flag restarts the sequence
      offer_request(-32'sd2147483648, 1'b0);
      offer_request(-32'sd2147483648, 1'b0);
      offer_request(-32'sd2147483648, 1'b1);       // first flags back to back
      offer_request(32'sd0, 1'b1);
      for (k = 5; k > 0; k--) offer_request(k, 1'b0);   // strictly decreasing
      offer_request(32'h5555_5555, 1'b0);
      offer_request(32'hAAAA_AAAA, 1'b0);
      offer_request(32'h7FFF_FFFE, 1'b0);
      offer_request(32'h8000_0001, 1'b1);
      offer_request(32'h0000_0001, 1'b0);
      offer_request(32'hFFFF_FFFF, 1'b0);

      // Sender idles lightly, receiver heavily, and one long hold-off fills
      // the block while the sender keeps offering.
      send_idle_pct = 15;
      recv_idle_pct = 56;
      hold_pending  = 1'b1;
      random_phase(100);

      send_idle_pct = 56;
      recv_idle_pct = 15;
      random_phase(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      fill_store();
      random_phase(20);

      req_valid <= 1'b0;
      while (tracker.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0 && tracker.awaited_results.size() == 0) begin
         $display("longest_nondecreasing_subsequence_core: match");
      end else begin
         $display("longest_nondecreasing_subsequence_core: mismatch");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lnds_pkg.sv
rtl/lnds_ram.sv
rtl/lnds_engine.sv
rtl/longest_nondecreasing_subsequence_core.sv
tb/longest_nondecreasing_subsequence_core_tb.sv
